// ===== rtl/mpfc_pkg.sv =====
// shared constants, types and the arctangent table of the marker pose block
package mpfc_pkg;

    // stream and field widths
    localparam int ID_W      = 10;
    localparam int IN_W      = 16;
    localparam int PIX_W     = 12;
    localparam int FRAC_BITS = 4;
    localparam int NUM_COORD = 8;
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 224;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W     = 24;
    localparam int OFF_W      = 32;
    localparam int HEAD_W     = 15;
    localparam int WHEAD_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SCALED_COS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALED_SIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_ANGLE = 3'd4;

    localparam logic [COEF_W-1:0] SCALED_COS_RST = 24'd1048576;

    // cordic datapath
    localparam int CORD_W    = 31;
    localparam int ANG_W     = 16;
    localparam int ATAN_LEN  = 24;
    localparam int CORD_GAIN_SHIFT = 12;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd6434;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd12868;

    // defaults for the top level parameters
    localparam int PIXEL_BITS_DEF   = 12;
    localparam int CORDIC_STEPS_DEF = 14;

    // per-marker geometry carried alongside the cordic
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [PIX_W-1:0] mx;
        logic [PIX_W-1:0] my;
    } t_geom;

    // cordic vector state
    typedef struct packed {
        logic                     zero;
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } t_vec;

    // atan(2^-i) in q3.12, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_q12(input int step);
        logic [ANG_W-1:0] v;
        case (step)
            0:       v = 16'd3217;
            1:       v = 16'd1899;
            2:       v = 16'd1003;
            3:       v = 16'd509;
            4:       v = 16'd256;
            5:       v = 16'd128;
            6:       v = 16'd64;
            7:       v = 16'd32;
            8:       v = 16'd16;
            9:       v = 16'd8;
            10:      v = 16'd4;
            11:      v = 16'd2;
            12:      v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/marker_pose_from_corners.sv =====
// top level of the marker pose block: config registers, pipeline and stream ports
//
// Takes one detected marker per item (id plus four corners in pixels with four
// fraction bits) and returns one result item with the truncated first corner,
// the center from two truncated pair midpoints, the first-edge heading from a
// vectoring cordic in q3.12 radians, corner and center mapped to saturated
// q16.16 world coordinates, and the world heading (camera heading minus the
// mounting angle, not wrapped). The block is fully pipelined and accepts one
// item every clock while the skid entry is empty: one prep stage, one stage per
// cordic iteration, three stages for the world mapping and the output register.
// A one-entry skid behind the output register keeps s_tready registered; the
// input side only stalls once both output entries are full. Configuration
// writes are applied at once and must only happen while no item is in flight;
// writes to an unused register index are dropped.
module marker_pose_from_corners #(
    parameter int PIXEL_BITS   = mpfc_pkg::PIXEL_BITS_DEF,
    parameter int CORDIC_STEPS = mpfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [mpfc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mpfc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // marker_id, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y, zero pad
    input  logic [mpfc_pkg::S_TDATA_W-1:0]    s_tdata,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_id, cam_corner_x, cam_corner_y, cam_center_x, cam_center_y, edge_heading,
    // world_corner_x, world_corner_y, world_center_x, world_center_y, world_heading, pad
    output logic [mpfc_pkg::M_TDATA_W-1:0]    m_tdata
);

    // iterations past ATAN_LEN are not carried out
    localparam int NSTEP = (CORDIC_STEPS < mpfc_pkg::ATAN_LEN) ? CORDIC_STEPS
                           : mpfc_pkg::ATAN_LEN;
    // prep, cordic iterations, three world stages
    localparam int NSTG  = NSTEP + 4;

    // configuration registers
    logic signed [mpfc_pkg::COEF_W-1:0] r_scaled_cos, r_scaled_sin;
    logic signed [mpfc_pkg::OFF_W-1:0]  r_offset_x, r_offset_y;
    logic signed [mpfc_pkg::HEAD_W-1:0] r_offset_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaled_cos   <= mpfc_pkg::SCALED_COS_RST;
            r_scaled_sin   <= '0;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_offset_angle <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                mpfc_pkg::REG_SCALED_COS:   r_scaled_cos   <= i_cfg_wdata[mpfc_pkg::COEF_W-1:0];
                mpfc_pkg::REG_SCALED_SIN:   r_scaled_sin   <= i_cfg_wdata[mpfc_pkg::COEF_W-1:0];
                mpfc_pkg::REG_OFFSET_X:     r_offset_x     <= i_cfg_wdata;
                mpfc_pkg::REG_OFFSET_Y:     r_offset_y     <= i_cfg_wdata;
                mpfc_pkg::REG_OFFSET_ANGLE: r_offset_angle <= i_cfg_wdata[mpfc_pkg::HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together; the output skid absorbs one stalled item
    logic en;
    logic [NSTG-1:0] r_v;

    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], s_tvalid};
        end
    end

    // unpack the input item
    logic [mpfc_pkg::NUM_COORD-1:0][mpfc_pkg::IN_W-1:0] in_coord;

    always_comb begin
        for (int k = 0; k < mpfc_pkg::NUM_COORD; k++) begin
            in_coord[k] = s_tdata[mpfc_pkg::ID_W + k*mpfc_pkg::IN_W +: mpfc_pkg::IN_W];
        end
    end

    mpfc_pkg::t_geom w_geom [NSTG];
    mpfc_pkg::t_vec  w_vec  [NSTEP+1];

    mpfc_prep #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_id    (s_tdata[mpfc_pkg::ID_W-1:0]),
        .i_coord (in_coord),
        .o_geom  (w_geom[0]),
        .o_vec   (w_vec[0])
    );

    // geometry rides along with the cordic and the world stages
    for (genvar k = 1; k < NSTG; k++) begin : g_geom
        mpfc_pkg::t_geom r_g;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_g <= w_geom[k-1];
            end
        end
        assign w_geom[k] = r_g;
    end

    // one cordic iteration per stage
    for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
        mpfc_cordic_step #(
            .STEP (i)
        ) u_step (
            .i_clk (i_clk),
            .i_en  (en),
            .i_vec (w_vec[i]),
            .o_vec (w_vec[i+1])
        );
    end

    // heading: clamp, then subtract mounting angle, then hold for the last world stage
    logic signed [mpfc_pkg::ANG_W-1:0]   zf;
    logic signed [mpfc_pkg::HEAD_W-1:0]  n_head1;
    logic signed [mpfc_pkg::HEAD_W-1:0]  r_head1, r_head2, r_head3;
    logic signed [mpfc_pkg::WHEAD_W-1:0] r_wh2, r_wh3;

    always_comb begin
        zf = w_vec[NSTEP].z;
        if (w_vec[NSTEP].zero) begin
            n_head1 = '0;
        end else if (zf > mpfc_pkg::ANG_PI) begin
            n_head1 = mpfc_pkg::ANG_PI[mpfc_pkg::HEAD_W-1:0];
        end else if (zf < -mpfc_pkg::ANG_PI) begin
            n_head1 = mpfc_pkg::HEAD_W'(-mpfc_pkg::ANG_PI);
        end else begin
            n_head1 = zf[mpfc_pkg::HEAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head1 <= n_head1;
            r_head2 <= r_head1;
            r_wh2   <= mpfc_pkg::WHEAD_W'(r_head1) - mpfc_pkg::WHEAD_W'(r_offset_angle);
            r_head3 <= r_head2;
            r_wh3   <= r_wh2;
        end
    end

    // world mapping of corner and center
    logic signed [mpfc_pkg::OFF_W-1:0] wc_x, wc_y, wm_x, wm_y;

    mpfc_world u_world_corner (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_p     (w_geom[NSTEP].px),
        .i_q     (w_geom[NSTEP].py),
        .i_cos   (r_scaled_cos),
        .i_sin   (r_scaled_sin),
        .i_off_x (r_offset_x),
        .i_off_y (r_offset_y),
        .o_wx    (wc_x),
        .o_wy    (wc_y)
    );

    mpfc_world u_world_center (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_p     (w_geom[NSTEP].mx),
        .i_q     (w_geom[NSTEP].my),
        .i_cos   (r_scaled_cos),
        .i_sin   (r_scaled_sin),
        .i_off_x (r_offset_x),
        .i_off_y (r_offset_y),
        .o_wx    (wm_x),
        .o_wy    (wm_y)
    );

    // pack the result item
    logic [mpfc_pkg::M_TDATA_W-1:0] res_data;
    mpfc_pkg::t_geom                g_last;

    assign g_last   = w_geom[NSTG-1];
    assign res_data = {7'b0, r_wh3, wm_y, wm_x, wc_y, wc_x, r_head3,
                       g_last.my, g_last.mx, g_last.py, g_last.px, g_last.id};

    mpfc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NSTG-1]),
        .i_data  (res_data),
        .o_ready (en),
        .o_valid (m_tvalid),
        .o_data  (m_tdata),
        .i_ready (m_tready)
    );

endmodule

// ===== rtl/mpfc_prep.sv =====
// first stage: corner masking, truncated corner, center, edge vector and half-plane fold
module mpfc_prep #(
    parameter int PIXEL_BITS = mpfc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [mpfc_pkg::ID_W-1:0]                         i_id,
    input  logic [mpfc_pkg::NUM_COORD-1:0][mpfc_pkg::IN_W-1:0] i_coord,
    output mpfc_pkg::t_geom                                   o_geom,
    output mpfc_pkg::t_vec                                    o_vec
);

    localparam int IW = mpfc_pkg::IN_W;
    localparam int CW = (PIXEL_BITS + mpfc_pkg::FRAC_BITS > IW) ? IW
                        : PIXEL_BITS + mpfc_pkg::FRAC_BITS;
    localparam logic [IW:0]   ONE_AT_CW = (IW+1)'(1) << CW;
    localparam logic [IW-1:0] CMASK     = IW'(ONE_AT_CW - 1'b1);

    logic [mpfc_pkg::NUM_COORD-1:0][IW-1:0] m;
    logic [IW:0]                  s_x1, s_x2, s_y1, s_y2;
    logic [mpfc_pkg::PIX_W:0]     t_x, t_y;
    logic signed [IW:0]           dx, dy, xp, yp;
    logic signed [mpfc_pkg::ANG_W-1:0] z0;
    mpfc_pkg::t_geom              n_geom;
    mpfc_pkg::t_vec               n_vec;
    mpfc_pkg::t_geom              r_geom;
    mpfc_pkg::t_vec               r_vec;

    always_comb begin
        for (int k = 0; k < mpfc_pkg::NUM_COORD; k++) begin
            m[k] = i_coord[k] & CMASK;
        end

        // pair midpoints, each truncated before the final average
        s_x1 = {1'b0, m[0]} + {1'b0, m[2]};
        s_x2 = {1'b0, m[4]} + {1'b0, m[6]};
        s_y1 = {1'b0, m[1]} + {1'b0, m[5]};
        s_y2 = {1'b0, m[3]} + {1'b0, m[7]};
        t_x  = {1'b0, s_x1[IW:5]} + {1'b0, s_x2[IW:5]};
        t_y  = {1'b0, s_y1[IW:5]} + {1'b0, s_y2[IW:5]};

        // first edge, folded into the right half plane
        dx = $signed({1'b0, m[2]}) - $signed({1'b0, m[0]});
        dy = $signed({1'b0, m[3]}) - $signed({1'b0, m[1]});
        if (dx < 0 && dy >= 0) begin
            xp = dy;
            yp = -dx;
            z0 = mpfc_pkg::ANG_HALF_PI;
        end else if (dx < 0) begin
            xp = -dy;
            yp = dx;
            z0 = -mpfc_pkg::ANG_HALF_PI;
        end else begin
            xp = dx;
            yp = dy;
            z0 = '0;
        end

        n_geom.id = i_id;
        n_geom.px = m[0][IW-1:mpfc_pkg::FRAC_BITS];
        n_geom.py = m[1][IW-1:mpfc_pkg::FRAC_BITS];
        n_geom.mx = t_x[mpfc_pkg::PIX_W:1];
        n_geom.my = t_y[mpfc_pkg::PIX_W:1];

        n_vec.zero = (dx == 0) && (dy == 0);
        n_vec.x    = mpfc_pkg::CORD_W'(xp) <<< mpfc_pkg::CORD_GAIN_SHIFT;
        n_vec.y    = mpfc_pkg::CORD_W'(yp) <<< mpfc_pkg::CORD_GAIN_SHIFT;
        n_vec.z    = z0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom <= n_geom;
            r_vec  <= n_vec;
        end
    end

    assign o_geom = r_geom;
    assign o_vec  = r_vec;

endmodule

// ===== rtl/mpfc_cordic_step.sv =====
// one registered vectoring-mode cordic iteration
module mpfc_cordic_step #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  mpfc_pkg::t_vec i_vec,
    output mpfc_pkg::t_vec o_vec
);

    localparam logic signed [mpfc_pkg::ANG_W-1:0] ATAN_I = mpfc_pkg::atan_q12(STEP);

    logic signed [mpfc_pkg::CORD_W-1:0] xs, ys;
    mpfc_pkg::t_vec                     n_vec;
    mpfc_pkg::t_vec                     r_vec;

    always_comb begin
        xs = $signed(i_vec.x) >>> STEP;
        ys = $signed(i_vec.y) >>> STEP;
        n_vec.zero = i_vec.zero;
        if (!i_vec.y[mpfc_pkg::CORD_W-1]) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + ATAN_I;
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

// ===== rtl/mpfc_world.sv =====
// three-stage camera-to-world mapping of one point: products, rounded sums, offset with saturation
module mpfc_world (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [mpfc_pkg::PIX_W-1:0]              i_p,
    input  logic [mpfc_pkg::PIX_W-1:0]              i_q,
    input  logic signed [mpfc_pkg::COEF_W-1:0]      i_cos,
    input  logic signed [mpfc_pkg::COEF_W-1:0]      i_sin,
    input  logic signed [mpfc_pkg::OFF_W-1:0]       i_off_x,
    input  logic signed [mpfc_pkg::OFF_W-1:0]       i_off_y,
    output logic signed [mpfc_pkg::OFF_W-1:0]       o_wx,
    output logic signed [mpfc_pkg::OFF_W-1:0]       o_wy
);

    localparam int PW = mpfc_pkg::PIX_W + mpfc_pkg::COEF_W + 1;
    localparam int SW = PW + 1;
    localparam int RW = SW - mpfc_pkg::FRAC_BITS;
    localparam int OW = RW + 1;

    logic signed [PW-1:0] r_pc, r_qs, r_ps, r_qc;
    logic signed [SW-1:0] n_sx, n_sy;
    logic signed [RW-1:0] r_sx, r_sy;
    logic signed [OW-1:0] n_wx, n_wy;
    logic signed [mpfc_pkg::OFF_W-1:0] r_wx, r_wy;

    function automatic logic signed [mpfc_pkg::OFF_W-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [mpfc_pkg::OFF_W-1:0] r;
        if (v[OW-1:mpfc_pkg::OFF_W-1] == '0 || v[OW-1:mpfc_pkg::OFF_W-1] == '1) begin
            r = v[mpfc_pkg::OFF_W-1:0];
        end else if (v[OW-1]) begin
            r = {1'b1, {(mpfc_pkg::OFF_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(mpfc_pkg::OFF_W-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb begin
        n_sx = SW'(r_pc) + SW'(r_qs) + SW'(8);
        n_sy = SW'(r_qc) - SW'(r_ps) + SW'(8);
        n_wx = OW'(r_sx) + OW'(i_off_x);
        n_wy = OW'(r_sy) + OW'(i_off_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc <= $signed({1'b0, i_p}) * i_cos;
            r_qs <= $signed({1'b0, i_q}) * i_sin;
            r_ps <= $signed({1'b0, i_p}) * i_sin;
            r_qc <= $signed({1'b0, i_q}) * i_cos;
            // floor shift by the four fraction bits
            r_sx <= n_sx[SW-1:mpfc_pkg::FRAC_BITS];
            r_sy <= n_sy[SW-1:mpfc_pkg::FRAC_BITS];
            r_wx <= sat(n_wx);
            r_wy <= sat(n_wy);
        end
    end

    assign o_wx = r_wx;
    assign o_wy = r_wy;

endmodule

// ===== rtl/mpfc_out_buf.sv =====
// output register with one skid entry so the pipeline keeps moving under a single stall
module mpfc_out_buf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [mpfc_pkg::M_TDATA_W-1:0]   i_data,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic [mpfc_pkg::M_TDATA_W-1:0]   o_data,
    input  logic                             i_ready
);

    logic                           r_out_v, r_skd_v;
    logic [mpfc_pkg::M_TDATA_W-1:0] r_out_d, r_skd_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else if (r_skd_v) begin
            if (i_ready) begin
                r_skd_v <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_v || i_ready) begin
                r_out_v <= 1'b1;
            end else begin
                r_skd_v <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_v) begin
            if (i_ready) begin
                r_out_d <= r_skd_d;
            end
        end else if (i_valid) begin
            if (!r_out_v || i_ready) begin
                r_out_d <= i_data;
            end else begin
                r_skd_d <= i_data;
            end
        end
    end

    assign o_ready = !r_skd_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

endmodule

// ===== tb/marker_pose_from_corners_tb.sv =====
// self-checking testbench of marker_pose_from_corners: directed and random markers vs a predictor
`timescale 1ns / 100ps

module marker_pose_from_corners_tb;
    import mpfc_pkg::*;

    // pipeline depth at the default cordic length, used for the closing wait
    localparam int PIPE_LATENCY   = CORDIC_STEPS_DEF + 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_FIELDS     = 11;

    // angle constants of the heading predictor, q3.12 radians
    localparam longint QUARTER_TURN_Q12 = 6434;
    localparam longint HALF_TURN_Q12    = 12868;
    localparam longint ARCTAN_Q12 [0:12] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16,
                                            8, 4, 2, 1};

    // result item layout from the lowest bit up
    localparam int FIELD_LSB [NUM_FIELDS] = '{0, 10, 22, 34, 46, 58, 73, 105, 137, 169, 201};
    localparam int FIELD_W   [NUM_FIELDS] = '{10, 12, 12, 12, 12, 15, 32, 32, 32, 32, 16};

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [3:0][IN_W-1:0]     cx;
        logic [3:0][IN_W-1:0]     cy;
    } marker_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PIX_W-1:0]   corner_x;
        logic [PIX_W-1:0]   corner_y;
        logic [PIX_W-1:0]   center_x;
        logic [PIX_W-1:0]   center_y;
        logic [HEAD_W-1:0]  cam_head;
        logic [OFF_W-1:0]   wcorner_x;
        logic [OFF_W-1:0]   wcorner_y;
        logic [OFF_W-1:0]   wcenter_x;
        logic [OFF_W-1:0]   wcenter_y;
        logic [WHEAD_W-1:0] world_head;
    } pose_t;

    // one line of the directed table; typed rows carry their own pose
    typedef struct packed {
        marker_t m;
        logic    typed;
        pose_t   want;
    } directed_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // marker_id, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y, zero pad
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // out_id, cam_corner_x, cam_corner_y, cam_center_x, cam_center_y, edge_heading,
    // world_corner_x, world_corner_y, world_center_x, world_center_y, world_heading, pad
    logic [M_TDATA_W-1:0]    m_tdata;

    // predictor copy of the mounting registers, at their reset values
    logic signed [COEF_W-1:0] mount_cos = SCALED_COS_RST;
    logic signed [COEF_W-1:0] mount_sin = '0;
    logic signed [OFF_W-1:0]  world_off_x = '0;
    logic signed [OFF_W-1:0]  world_off_y = '0;
    logic signed [HEAD_W-1:0] mount_angle = '0;

    pose_t         pose_queue [$];
    directed_row_t rows [$];
    int    mismatches = 0;
    int    tx_idle_pct = 29;
    int    rx_idle_pct = 83;
    int    hold_asked = 0;
    int    hold_taken = 0;
    int    hold_left = 0;
    int    quiet_cycles = 0;

    string field_label [NUM_FIELDS] = '{"out_id", "cam_corner_x", "cam_corner_y",
        "cam_center_x", "cam_center_y", "edge_heading", "world_corner_x", "world_corner_y",
        "world_center_x", "world_center_y", "world_heading"};

    marker_pose_from_corners uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // first-edge angle by a vectoring cordic, folded into the right half plane first
    function automatic longint edge_angle(longint dx, longint dy);
        longint x, y, z, t, xs, ys, da;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = QUARTER_TURN_Q12;
            end else begin
                t = x; x = -y; y = t; z = -QUARTER_TURN_Q12;
            end
        end
        x = x * 4096;
        y = y * 4096;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            da = (i < $size(ARCTAN_Q12)) ? ARCTAN_Q12[i] : 0;
            if (y >= 0) begin
                x += ys; y -= xs; z += da;
            end else begin
                x -= ys; y += xs; z -= da;
            end
        end
        // overshoot past half a turn is clamped
        if (z > HALF_TURN_Q12)
            z = HALF_TURN_Q12;
        if (z < -HALF_TURN_Q12)
            z = -HALF_TURN_Q12;
        return z;
    endfunction

    // round the q16.20 products to nearest q16.16, add the offset, saturate to int32
    function automatic logic [OFF_W-1:0] map_world(longint acc, longint off);
        longint v;
        v = ((acc + 8) >>> 4) + off;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return OFF_W'(v);
    endfunction

    function automatic pose_t predict_pose(marker_t m);
        pose_t  p;
        longint px, py, mx, my, cx1, cx2, cy1, cy2, head, cosv, sinv;
        px = m.cx[0] >> FRAC_BITS;
        py = m.cy[0] >> FRAC_BITS;
        // center from the truncated pair midpoints, pairs differ for x and y
        cx1 = (longint'(m.cx[0]) + longint'(m.cx[1])) >>> (FRAC_BITS + 1);
        cx2 = (longint'(m.cx[2]) + longint'(m.cx[3])) >>> (FRAC_BITS + 1);
        cy1 = (longint'(m.cy[0]) + longint'(m.cy[2])) >>> (FRAC_BITS + 1);
        cy2 = (longint'(m.cy[1]) + longint'(m.cy[3])) >>> (FRAC_BITS + 1);
        mx = ((cx1 + cx2) >>> 1) & 12'hFFF;
        my = ((cy1 + cy2) >>> 1) & 12'hFFF;
        head = edge_angle(longint'(m.cx[1]) - longint'(m.cx[0]),
                          longint'(m.cy[1]) - longint'(m.cy[0]));
        cosv = mount_cos;
        sinv = mount_sin;
        p.id         = m.id;
        p.corner_x   = PIX_W'(px);
        p.corner_y   = PIX_W'(py);
        p.center_x   = PIX_W'(mx);
        p.center_y   = PIX_W'(my);
        p.cam_head   = HEAD_W'(head);
        p.wcorner_x  = map_world(px * cosv + py * sinv, world_off_x);
        p.wcorner_y  = map_world(-(px * sinv) + py * cosv, world_off_y);
        p.wcenter_x  = map_world(mx * cosv + my * sinv, world_off_x);
        p.wcenter_y  = map_world(-(mx * sinv) + my * cosv, world_off_y);
        p.world_head = WHEAD_W'(head - longint'(mount_angle));
        return p;
    endfunction

    // ---------------------------------------------------------------- packing

    function automatic logic [S_TDATA_W-1:0] pack_marker(marker_t m);
        logic [S_TDATA_W-1:0] v;
        v = '0;
        v[ID_W-1:0] = m.id;
        for (int k = 0; k < 4; k++) begin
            v[ID_W + 32*k +: IN_W]      = m.cx[k];
            v[ID_W + 32*k + 16 +: IN_W] = m.cy[k];
        end
        return v;
    endfunction

    function automatic logic [M_TDATA_W-1:0] pack_pose(pose_t p);
        logic [M_TDATA_W-1:0] v;
        v = '0;
        v[9:0]     = p.id;
        v[21:10]   = p.corner_x;
        v[33:22]   = p.corner_y;
        v[45:34]   = p.center_x;
        v[57:46]   = p.center_y;
        v[72:58]   = p.cam_head;
        v[104:73]  = p.wcorner_x;
        v[136:105] = p.wcorner_y;
        v[168:137] = p.wcenter_x;
        v[200:169] = p.wcenter_y;
        v[216:201] = p.world_head;
        return v;
    endfunction

    function automatic marker_t corners(int id, int c0x, int c0y, int c1x, int c1y,
                                        int c2x, int c2y, int c3x, int c3y);
        marker_t m;
        m.id    = ID_W'(id);
        m.cx[0] = IN_W'(c0x); m.cy[0] = IN_W'(c0y);
        m.cx[1] = IN_W'(c1x); m.cy[1] = IN_W'(c1y);
        m.cx[2] = IN_W'(c2x); m.cy[2] = IN_W'(c2y);
        m.cx[3] = IN_W'(c3x); m.cy[3] = IN_W'(c3y);
        return m;
    endfunction

    function automatic logic [IN_W-1:0] clip_coord(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return IN_W'(v);
    endfunction

    // mostly square markers of random size and turn, some noise, some tiny edges
    function automatic marker_t random_marker();
        marker_t m;
        int      kind, px0, py0, ex, ey, span;
        m.id = ID_W'($urandom);
        for (int k = 0; k < 4; k++) begin
            m.cx[k] = IN_W'($urandom);
            m.cy[k] = IN_W'($urandom);
        end
        kind = $urandom_range(99);
        if (kind < 60) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(1600);
            ex   = int'($urandom_range(2 * span)) - span;
            ey   = int'($urandom_range(2 * span)) - span;
            px0  = $urandom_range(65535);
            py0  = $urandom_range(65535);
            m.cx[0] = clip_coord(px0);           m.cy[0] = clip_coord(py0);
            m.cx[1] = clip_coord(px0 + ex);      m.cy[1] = clip_coord(py0 + ey);
            m.cx[2] = clip_coord(px0 + ex - ey); m.cy[2] = clip_coord(py0 + ey + ex);
            m.cx[3] = clip_coord(px0 - ey);      m.cy[3] = clip_coord(py0 + ex);
        end else if (kind >= 85) begin
            // first edge of a few sixteenths at most, zero length included
            m.cx[1] = clip_coord(int'(m.cx[0]) + int'($urandom_range(4)) - 2);
            m.cy[1] = clip_coord(int'(m.cy[0]) + int'($urandom_range(4)) - 2);
        end
        return m;
    endfunction

    // append one line to the directed table
    task automatic add_row(input marker_t m, input logic typed, input pose_t want);
        directed_row_t r;
        r.m     = m;
        r.typed = typed;
        r.want  = want;
        rows.insert(rows.size(), r);
    endtask

    // ---------------------------------------------------------------- drivers

    task automatic send_marker(input marker_t m, input logic typed, input pose_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tdata  <= pack_marker(m);
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pose_queue.insert(pose_queue.size(), typed ? want : predict_pose(m));
    endtask

    // stop offering items and wait for every pending pose
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pose_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_SCALED_COS:   mount_cos   = data[COEF_W-1:0];
            REG_SCALED_SIN:   mount_sin   = data[COEF_W-1:0];
            REG_OFFSET_X:     world_off_x = data[OFF_W-1:0];
            REG_OFFSET_Y:     world_off_y = data[OFF_W-1:0];
            REG_OFFSET_ANGLE: mount_angle = data[HEAD_W-1:0];
            default: ;
        endcase
    endtask

    // all five mounting registers, then junk to the unused indexes, which must be dropped
    task automatic set_mount(input logic [31:0] cosw, input logic [31:0] sinw,
                             input logic [31:0] offxw, input logic [31:0] offyw,
                             input logic [31:0] angw);
        write_reg(REG_SCALED_COS, cosw);
        write_reg(REG_SCALED_SIN, sinw);
        write_reg(REG_OFFSET_X, offxw);
        write_reg(REG_OFFSET_Y, offyw);
        write_reg(REG_OFFSET_ANGLE, angw);
        for (int a = REG_OFFSET_ANGLE + 1; a < (1 << CFG_ADDR_W); a++)
            write_reg(CFG_ADDR_W'(a), $urandom);
    endtask

    // ---------------------------------------------------------------- receiver side

    // random back-pressure, with a long hold whenever the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // field-by-field check of each result item against the oldest pending pose
    always @(posedge i_clk) begin
        logic [M_TDATA_W-1:0] want_bits, fmask, exp_f, got_f;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pose_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result item with no marker pending: %h", m_tdata);
            end else begin
                want_bits = pack_pose(pose_queue.pop_front());
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    fmask = (M_TDATA_W'(1) << FIELD_W[f]) - 1;
                    exp_f = (want_bits >> FIELD_LSB[f]) & fmask;
                    got_f = (m_tdata >> FIELD_LSB[f]) & fmask;
                    if (got_f !== exp_f) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%s: expected %h, got %h (id %h)", field_label[f],
                                     exp_f[31:0], got_f[31:0], want_bits[ID_W-1:0]);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d poses pending", pose_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        pose_t         blank, full, frac_only;
        int            ang;
        logic [31:0]   junk;

        blank = '0;
        // all corners at the top of the range, reset mounting (unit cos, no offsets)
        full            = '0;
        full.id         = 10'h3FF;
        full.corner_x   = 12'hFFF;
        full.corner_y   = 12'hFFF;
        full.center_x   = 12'hFFF;
        full.center_y   = 12'hFFF;
        full.wcorner_x  = 32'h0FFF_0000;
        full.wcorner_y  = 32'h0FFF_0000;
        full.wcenter_x  = 32'h0FFF_0000;
        full.wcenter_y  = 32'h0FFF_0000;
        // fraction bits only truncate away entirely
        frac_only    = '0;
        frac_only.id = 10'h2AA;

        add_row(corners(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, blank);
        add_row(corners(1023, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
                        'hFFFF, 'hFFFF), 1'b1, full);
        add_row(corners('h2AA, 'hF, 'hF, 'hF, 'hF, 'hF, 'hF, 'hF, 'hF), 1'b1, frac_only);
        // first edge along each axis at full length and at one sixteenth
        add_row(corners('h155, 0, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF, 0, 'hFFFF), 1'b0, blank);
        add_row(corners(1, 'hFFFF, 0, 0, 0, 'h1234, 'h4321, 'h0F0F, 'hF0F0), 1'b0, blank);
        add_row(corners(2, 'hFFFF, 0, 0, 1, 'h8000, 'h7FFF, 'h0001, 'hFFFE), 1'b0, blank);
        add_row(corners(3, 'hFFFF, 1, 0, 0, 'h3C3C, 'hC3C3, 'h00FF, 'hFF00), 1'b0, blank);
        add_row(corners(4, 16, 16, 17, 16, 17, 17, 16, 17), 1'b0, blank);
        add_row(corners(5, 17, 16, 16, 16, 16, 17, 17, 17), 1'b0, blank);
        add_row(corners(6, 100, 100, 100, 101, 99, 101, 99, 100), 1'b0, blank);
        add_row(corners(7, 100, 101, 100, 100, 101, 100, 101, 101), 1'b0, blank);
        add_row(corners(8, 0, 0, 0, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0), 1'b0, blank);
        add_row(corners(9, 0, 'hFFFF, 0, 0, 'hFFFF, 0, 'hFFFF, 'hFFFF), 1'b0, blank);
        // unit diagonals in the three quadrants other than the first, full diagonals in the first and third
        add_row(corners(10, 50, 50, 49, 49, 48, 50, 49, 51), 1'b0, blank);
        add_row(corners(11, 50, 50, 51, 49, 52, 50, 51, 51), 1'b0, blank);
        add_row(corners(12, 50, 50, 49, 51, 50, 52, 51, 51), 1'b0, blank);
        add_row(corners(13, 0, 0, 'hFFFF, 'hFFFF, 0, 'hFFFF, 'hFFFF, 0), 1'b0, blank);
        add_row(corners(14, 'hFFFF, 'hFFFF, 0, 0, 'hFFFF, 0, 0, 'hFFFF), 1'b0, blank);
        // alternating bit patterns
        add_row(corners('h2AA, 'hAAAA, 'h5555, 'h5555, 'hAAAA, 'hAAAA, 'h5555,
                        'h5555, 'hAAAA), 1'b0, blank);
        add_row(corners('h155, 'h5555, 'hAAAA, 'hAAAA, 'h5555, 'h5555, 'hAAAA,
                        'hAAAA, 'h5555), 1'b0, blank);
        // an ordinary slightly turned marker
        add_row(corners('h123, 'h6400, 'h3200, 'h6A00, 'h3300, 'h6900, 'h3900,
                        'h6300, 'h3800), 1'b0, blank);

        // reset held at the start, once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        foreach (rows[r])
            send_marker(rows[r].m, rows[r].typed, rows[r].want);
        drain();

        // random register words, upper bits of the narrow registers filled with junk
        ang  = int'($urandom_range(25736)) - 12868;
        junk = $urandom;
        set_mount($urandom, $urandom, $urandom, $urandom, {junk[31:HEAD_W], ang[HEAD_W-1:0]});
        repeat (170)
            send_marker(random_marker(), 1'b0, blank);
        drain();

        // sender idles heavily, receiver lightly; both coefficient extremes
        tx_idle_pct <= 83;
        rx_idle_pct <= 29;
        set_mount(32'h007F_FFFF, 32'hFF80_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd12868);
        repeat (90)
            send_marker(random_marker(), 1'b0, blank);
        drain();
        set_mount(32'hFF80_0000, 32'h007F_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd12868);
        repeat (90)
            send_marker(random_marker(), 1'b0, blank);
        drain();

        // no idling on either side; plausible scale, long hold and a full drain mid-run
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        ang = int'($urandom_range(25736)) - 12868;
        set_mount(32'(int'($urandom_range(1 << 23)) - (1 << 22)),
                  32'(int'($urandom_range(1 << 23)) - (1 << 22)),
                  $urandom, $urandom, 32'(ang));
        for (int n = 0; n < 180; n++) begin
            if (n == 60)
                hold_asked <= hold_asked + 1;
            if (n == 120)
                drain();
            send_marker(random_marker(), 1'b0, blank);
        end
        drain();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mpfc_pkg.sv
rtl/mpfc_prep.sv
rtl/mpfc_cordic_step.sv
rtl/mpfc_world.sv
rtl/mpfc_out_buf.sv
rtl/marker_pose_from_corners.sv
tb/marker_pose_from_corners_tb.sv
